FILE: hdl/tln_pkg.sv
// shared types, constants and helpers for the torus lattice neighbor block
// no dependencies; used by every other file of the block except tln_if
package tln_pkg;

    localparam int SIDE_W = 9;
    localparam int NODE_W = 16;
    localparam int SLOT_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_LATTICE    = 2'd2;

    // neighbor slot codes
    localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_UP     = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_UPDIAG = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DOWN   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_DNDIAG = 3'd5;
    // square lattice puts down right after up
    localparam logic [SLOT_W-1:0] SLOT_SQ_DOWN = 3'd3;

    typedef enum logic [1:0] {
        KIND_SQUARE   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_HEXAGON  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_DONE
    } t_front_state;

    // clamped grid geometry and lattice kind
    typedef struct packed {
        logic [SIDE_W-1:0] len;
        logic [SIDE_W-1:0] hgt;
        logic [1:0]        kind;
    } t_geom;

    // one classified node handed from front to back
    typedef struct packed {
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
        logic              err;
    } t_work;

    function automatic logic [SLOT_W-1:0] kind_count(input logic [1:0] kind);
        logic [SLOT_W-1:0] n;
        unique case (kind)
            KIND_SQUARE:   n = 3'd4;
            KIND_TRIANGLE: n = 3'd3;
            KIND_HEXAGON:  n = 3'd6;
            default:       n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/tln_if.sv
// valid/ready channel interfaces for node requests and neighbor results
// no dependencies
interface tln_node_if;
    logic        valid;
    logic        ready;
    logic [15:0] node_index;

    modport source (output valid, output node_index, input ready);
    modport sink   (input valid, input node_index, output ready);
endinterface

interface tln_nbr_if;
    logic        valid;
    logic        ready;
    logic [15:0] neighbor_index;
    logic [2:0]  neighbor_slot;
    logic        last_neighbor;
    logic        index_error;

    modport source (output valid, output neighbor_index, output neighbor_slot,
                    output last_neighbor, output index_error, input ready);
    modport sink   (input valid, input neighbor_index, input neighbor_slot,
                    input last_neighbor, input index_error, output ready);
endinterface

FILE: hdl/tln_front.sv
// front end: accepts a node, range checks it and splits it into row and column
// depends on tln_pkg and tln_node_if
module tln_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tln_node_if.sink           i_node,
    input  tln_pkg::t_geom     i_geom,
    output logic               o_push,
    output tln_pkg::t_work     o_work,
    input  logic               i_full
);

    localparam int BITS_PER_STEP = 3;
    localparam logic [1:0] LAST_STEP = 2'd2;

    tln_pkg::t_front_state r_state, n_state;

    logic [1:0]  r_cnt;
    logic [8:0]  r_rem, n_rem;
    logic [8:0]  r_quo, n_quo;
    logic [8:0]  r_lo, n_lo;
    logic        r_err;
    logic [17:0] size;
    logic        in_range;
    logic        accept;
    logic [9:0]  trial;

    assign size     = 18'(i_geom.len) * 18'(i_geom.hgt);
    assign in_range = {2'b00, i_node.node_index} < size;
    assign accept   = i_node.valid && i_node.ready;

    // three restoring division steps per cycle; remainder always below len
    always_comb begin
        n_rem = r_rem;
        n_lo  = r_lo;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            trial = {n_rem, n_lo[8]};
            n_lo  = {n_lo[7:0], 1'b0};
            if (trial >= {1'b0, i_geom.len}) begin
                n_rem = 9'(trial - {1'b0, i_geom.len});
                n_quo = {n_quo[7:0], 1'b1};
            end else begin
                n_rem = trial[8:0];
                n_quo = {n_quo[7:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tln_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_node.ready = 1'b0;
        o_push       = 1'b0;
        unique case (r_state)
            tln_pkg::FS_IDLE: begin
                i_node.ready = 1'b1;
                if (i_node.valid) begin
                    n_state = in_range ? tln_pkg::FS_DIV : tln_pkg::FS_DONE;
                end
            end
            tln_pkg::FS_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = tln_pkg::FS_DONE;
                end
            end
            tln_pkg::FS_DONE: begin
                o_push = 1'b1;
                if (!i_full) begin
                    n_state = tln_pkg::FS_IDLE;
                end
            end
            default: n_state = tln_pkg::FS_IDLE;
        endcase
    end

    // node in range means node < len * 512, so its top 7 bits are below len
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err <= !in_range;
            r_rem <= {2'b00, i_node.node_index[15:9]};
            r_lo  <= i_node.node_index[8:0];
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_state == tln_pkg::FS_DIV) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
            r_quo <= n_quo;
            r_cnt <= r_cnt + 2'd1;
        end
    end

    assign o_work.row = r_quo;
    assign o_work.col = r_rem;
    assign o_work.err = r_err;

endmodule

FILE: hdl/tln_queue.sv
// short queue between front and back ends
// depends on tln_pkg
module tln_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tln_pkg::t_work  i_work,
    output logic            o_full,
    output logic            o_valid,
    output tln_pkg::t_work  o_work,
    input  logic            i_pop
);

    localparam int DEPTH = tln_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tln_pkg::t_work    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

endmodule

FILE: hdl/tln_back.sv
// back end: walks the neighbor slots of one node and drives the result channel
// depends on tln_pkg and tln_nbr_if
module tln_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tln_pkg::t_geom  i_geom,
    input  logic            i_valid,
    input  tln_pkg::t_work  i_work,
    output logic            o_pop,
    tln_nbr_if.source       o_nbr
);

    logic                              r_act;
    tln_pkg::t_work                    r_cur;
    logic [tln_pkg::SLOT_W-1:0]        r_slot;
    logic                              r_ovalid;
    logic [tln_pkg::NODE_W-1:0]        r_oidx;
    logic [tln_pkg::SLOT_W-1:0]        r_oslot;
    logic                              r_olast;
    logic                              r_oerr;

    logic [tln_pkg::SLOT_W-1:0]        count;
    logic                              out_free;
    logic                              advance;
    logic                              is_last;
    logic                              fin;
    logic [8:0]                        left, right, up, down, diag;
    logic [8:0]                        sel_row, sel_col;
    logic [17:0]                       idx;

    assign count    = r_cur.err ? 3'd1 : tln_pkg::kind_count(i_geom.kind);
    assign out_free = !r_ovalid || o_nbr.ready;
    assign advance  = r_act && ((count == '0) || out_free);
    assign is_last  = (r_slot == count - 3'd1);
    assign fin      = advance && ((count == '0) || is_last);
    assign o_pop    = i_valid && (!r_act || fin);

    // periodic wrap of the four axis neighbors
    assign left  = (r_cur.col == '0) ? i_geom.len - 9'd1 : r_cur.col - 9'd1;
    assign right = ({1'b0, r_cur.col} + 10'd1 == {1'b0, i_geom.len}) ? '0
                 : r_cur.col + 9'd1;
    assign up    = (r_cur.row == '0) ? i_geom.hgt - 9'd1 : r_cur.row - 9'd1;
    assign down  = ({1'b0, r_cur.row} + 10'd1 == {1'b0, i_geom.hgt}) ? '0
                 : r_cur.row + 9'd1;
    assign diag  = r_cur.row[0] ? right : left;

    always_comb begin
        sel_row = r_cur.row;
        sel_col = left;
        unique case (tln_pkg::t_kind'(i_geom.kind))
            tln_pkg::KIND_SQUARE: begin
                case (r_slot)
                    tln_pkg::SLOT_LEFT:    sel_col = left;
                    tln_pkg::SLOT_RIGHT:   sel_col = right;
                    tln_pkg::SLOT_UP: begin
                        sel_row = up;
                        sel_col = r_cur.col;
                    end
                    tln_pkg::SLOT_SQ_DOWN: begin
                        sel_row = down;
                        sel_col = r_cur.col;
                    end
                    default: sel_col = left;
                endcase
            end
            tln_pkg::KIND_TRIANGLE: begin
                case (r_slot)
                    tln_pkg::SLOT_LEFT:  sel_col = left;
                    tln_pkg::SLOT_RIGHT: sel_col = right;
                    tln_pkg::SLOT_UP: begin
                        // odd row + column parity points up, even points down
                        sel_row = (r_cur.row[0] ^ r_cur.col[0]) ? up : down;
                        sel_col = r_cur.col;
                    end
                    default: sel_col = left;
                endcase
            end
            tln_pkg::KIND_HEXAGON: begin
                case (r_slot)
                    tln_pkg::SLOT_LEFT:   sel_col = left;
                    tln_pkg::SLOT_RIGHT:  sel_col = right;
                    tln_pkg::SLOT_UP: begin
                        sel_row = up;
                        sel_col = r_cur.col;
                    end
                    tln_pkg::SLOT_UPDIAG: begin
                        sel_row = up;
                        sel_col = diag;
                    end
                    tln_pkg::SLOT_DOWN: begin
                        sel_row = down;
                        sel_col = r_cur.col;
                    end
                    tln_pkg::SLOT_DNDIAG: begin
                        sel_row = down;
                        sel_col = diag;
                    end
                    default: sel_col = left;
                endcase
            end
            default: sel_col = left;
        endcase
    end

    assign idx = 18'(sel_row) * 18'(i_geom.len) + 18'(sel_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (fin) begin
                r_act <= 1'b0;
            end
            if (advance && (count != '0)) begin
                r_ovalid <= 1'b1;
            end else if (o_nbr.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_work;
            r_slot <= '0;
        end else if (advance) begin
            r_slot <= r_slot + 3'd1;
        end
        if (advance && (count != '0)) begin
            r_oidx  <= r_cur.err ? '0 : idx[15:0];
            r_oslot <= r_slot;
            r_olast <= is_last;
            r_oerr  <= r_cur.err;
        end
    end

    assign o_nbr.valid          = r_ovalid;
    assign o_nbr.neighbor_index = r_oidx;
    assign o_nbr.neighbor_slot  = r_oslot;
    assign o_nbr.last_neighbor  = r_olast;
    assign o_nbr.index_error    = r_oerr;

endmodule

FILE: hdl/torus_lattice_neighbors.sv
// top level of the torus lattice neighbor block: configuration registers,
// front end, queue and back end; depends on tln_pkg, tln_if, tln_front,
// tln_queue and tln_back
//
// For each node index taken on i_node the block returns the node's neighbors
// on a row-major grid that wraps at its edges, one transaction per neighbor on
// o_nbr, in the order left, right, up, down for a square lattice; left, right,
// then down (even row + column) or up (odd) for a triangle lattice; left,
// right, up, up-diagonal, down, down-diagonal for a hexagon lattice, whose
// diagonal column is one to the right on odd rows and one to the left on even
// rows. The final transaction of a node carries last_neighbor. An index at or
// beyond row_length * row_count gives a single transaction with index_error,
// slot 0 and index 0; lattice kind 3 gives nothing for an index in range.
// Sides above MAX_SIDE are clamped to it. The front end takes one node at a
// time: it accepts the node, runs a 3-bit-per-cycle divider that splits the
// index into row and column, and hands the result off into a two-entry queue,
// waiting while the queue is full; an out-of-range index skips the divider.
// The back end emits one neighbor per cycle while o_nbr is ready, through a
// registered output. Registers sit at byte addresses 0 (row_length), 4
// (row_count) and 8 (lattice_kind) and are to be written only while no
// transaction is in flight.
module torus_lattice_neighbors #(
    parameter int MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tln_node_if.sink    i_node,
    tln_nbr_if.source   o_nbr
);

    // the side registers are 9 bits, so a cap above 511 never bites
    localparam int CAP = (MAX_SIDE > 511) ? 511 : MAX_SIDE;
    localparam logic [tln_pkg::SIDE_W-1:0] SIDE_CAP = tln_pkg::SIDE_W'(CAP);

    logic [8:0]       r_row_length;
    logic [8:0]       r_row_count;
    logic [1:0]       r_lattice;
    logic             cfg_wr;
    logic [1:0]       reg_sel;
    tln_pkg::t_geom   geom;

    logic             push;
    logic             full;
    tln_pkg::t_work   push_work;
    logic             q_valid;
    tln_pkg::t_work   q_work;
    logic             pop;

    // apb register file, pready always high
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= 9'd16;
            r_row_count  <= 9'd16;
            r_lattice    <= tln_pkg::KIND_SQUARE;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                tln_pkg::REG_ROW_LENGTH: r_row_length <= pwdata[8:0];
                tln_pkg::REG_ROW_COUNT:  r_row_count  <= pwdata[8:0];
                tln_pkg::REG_LATTICE:    r_lattice    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tln_pkg::REG_ROW_LENGTH: prdata = {23'd0, r_row_length};
            tln_pkg::REG_ROW_COUNT:  prdata = {23'd0, r_row_count};
            tln_pkg::REG_LATTICE:    prdata = {30'd0, r_lattice};
            default:                 prdata = '0;
        endcase
    end

    // clamped geometry shared by both ends
    assign geom.len  = (r_row_length > SIDE_CAP) ? SIDE_CAP : r_row_length;
    assign geom.hgt  = (r_row_count > SIDE_CAP) ? SIDE_CAP : r_row_count;
    assign geom.kind = r_lattice;

    // accept, range check, row / column split
    tln_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_node  (i_node),
        .i_geom  (geom),
        .o_push  (push),
        .o_work  (push_work),
        .i_full  (full)
    );

    // decouples the divider from the result stream
    tln_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (full),
        .o_valid (q_valid),
        .o_work  (q_work),
        .i_pop   (pop)
    );

    // neighbor walk and output register
    tln_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (q_valid),
        .i_work  (q_work),
        .o_pop   (pop),
        .o_nbr   (o_nbr)
    );

    // error transaction is always a lone slot-0, index-0 result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nbr.valid && o_nbr.index_error |->
            o_nbr.last_neighbor && (o_nbr.neighbor_slot == '0)
            && (o_nbr.neighbor_index == '0))
        else $error("error result not a lone slot-0 transaction");

    // every neighbor slot lies within the lattice's neighbor count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nbr.valid && !o_nbr.index_error |->
            o_nbr.neighbor_slot < tln_pkg::kind_count(geom.kind))
        else $error("neighbor slot beyond lattice neighbor count");

    // last flag sits exactly on the final slot of the lattice
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nbr.valid && !o_nbr.index_error |->
            o_nbr.last_neighbor
            == (o_nbr.neighbor_slot == tln_pkg::kind_count(geom.kind) - 3'd1))
        else $error("last flag does not match final neighbor slot");

    // front holds its handoff stable while the queue is full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && full |=> $stable(push_work))
        else $error("front handoff changed while queue full");

endmodule
